/* sv/qrv_pkg.sv */
// Package for the quaternion vector rotation block.
// Holds the payload structs and the internal widths and latencies.
// No dependencies.
package qrv_pkg;

    localparam int QRV_DW       = 16;  // width of every input component
    localparam int QRV_PW       = 32;  // first-level product width
    localparam int QRV_TW       = 33;  // t = q*p component width
    localparam int QRV_NW       = 33;  // squared norm width (unsigned)
    localparam int QRV_MW       = 49;  // second-level product width
    localparam int QRV_RW       = 50;  // r = t*conj(q) component width
    localparam int QRV_QBITS    = 17;  // quotient bits developed by the divider
    localparam int QRV_PROD_LAT = 4;
    localparam int QRV_DIV_LAT  = QRV_QBITS + 1;
    localparam int QRV_LAT      = QRV_PROD_LAT + QRV_DIV_LAT;

    typedef struct packed {
        logic signed [QRV_DW-1:0] quat_w;
        logic signed [QRV_DW-1:0] quat_x;
        logic signed [QRV_DW-1:0] quat_y;
        logic signed [QRV_DW-1:0] quat_z;
        logic signed [QRV_DW-1:0] vec_x;
        logic signed [QRV_DW-1:0] vec_y;
        logic signed [QRV_DW-1:0] vec_z;
    } t_qrv_in;

    typedef struct packed {
        logic signed [QRV_DW-1:0] rot_x;
        logic signed [QRV_DW-1:0] rot_y;
        logic signed [QRV_DW-1:0] rot_z;
        logic                     zero_norm;
        logic                     saturated;
    } t_qrv_out;

endpackage

/* sv/qrv_prod.sv */
// Product pipeline: forms t = q*(0,v), r = t*conj(q) and |q|^2 in four stages.
// Depends on qrv_pkg.
module qrv_prod (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  qrv_pkg::t_qrv_in                      i_data,
    output logic signed [qrv_pkg::QRV_RW-1:0]     o_rx,
    output logic signed [qrv_pkg::QRV_RW-1:0]     o_ry,
    output logic signed [qrv_pkg::QRV_RW-1:0]     o_rz,
    output logic        [qrv_pkg::QRV_NW-1:0]     o_norm,
    output logic                                  o_zero
);
    import qrv_pkg::*;

    // Stage 1: products of q and v, squares of q.
    logic signed [QRV_PW-1:0] r_p1 [0:11];
    logic signed [QRV_PW-1:0] r_sq [0:3];
    t_qrv_in                  r_d1;

    // Stage 2: t components and the norm.
    logic signed [QRV_TW-1:0] r_tw, r_tx, r_ty, r_tz;
    logic        [QRV_NW-1:0] r_n2;
    t_qrv_in                  r_d2;

    // Stage 3: products of t and q.
    logic signed [QRV_MW-1:0] r_p3 [0:11];
    logic        [QRV_NW-1:0] r_n3;

    // Stage 4: r components.
    logic signed [QRV_RW-1:0] r_rx, r_ry, r_rz;
    logic        [QRV_NW-1:0] r_n4;
    logic                     r_z4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1[0]  <= i_data.quat_x * i_data.vec_x;
            r_p1[1]  <= i_data.quat_y * i_data.vec_y;
            r_p1[2]  <= i_data.quat_z * i_data.vec_z;
            r_p1[3]  <= i_data.quat_w * i_data.vec_x;
            r_p1[4]  <= i_data.quat_y * i_data.vec_z;
            r_p1[5]  <= i_data.quat_z * i_data.vec_y;
            r_p1[6]  <= i_data.quat_w * i_data.vec_y;
            r_p1[7]  <= i_data.quat_x * i_data.vec_z;
            r_p1[8]  <= i_data.quat_z * i_data.vec_x;
            r_p1[9]  <= i_data.quat_w * i_data.vec_z;
            r_p1[10] <= i_data.quat_x * i_data.vec_y;
            r_p1[11] <= i_data.quat_y * i_data.vec_x;
            r_sq[0]  <= i_data.quat_w * i_data.quat_w;
            r_sq[1]  <= i_data.quat_x * i_data.quat_x;
            r_sq[2]  <= i_data.quat_y * i_data.quat_y;
            r_sq[3]  <= i_data.quat_z * i_data.quat_z;
            r_d1     <= i_data;

            r_tw <= -QRV_TW'(r_p1[0]) - QRV_TW'(r_p1[1]) - QRV_TW'(r_p1[2]);
            r_tx <=  QRV_TW'(r_p1[3]) + QRV_TW'(r_p1[4]) - QRV_TW'(r_p1[5]);
            r_ty <=  QRV_TW'(r_p1[6]) - QRV_TW'(r_p1[7]) + QRV_TW'(r_p1[8]);
            r_tz <=  QRV_TW'(r_p1[9]) + QRV_TW'(r_p1[10]) - QRV_TW'(r_p1[11]);
            // Squares are non-negative and at most 2^30.
            r_n2 <= {2'b00, r_sq[0][30:0]} + {2'b00, r_sq[1][30:0]}
                  + {2'b00, r_sq[2][30:0]} + {2'b00, r_sq[3][30:0]};
            r_d2 <= r_d1;

            r_p3[0]  <= r_tw * r_d2.quat_x;
            r_p3[1]  <= r_tx * r_d2.quat_w;
            r_p3[2]  <= r_ty * r_d2.quat_z;
            r_p3[3]  <= r_tz * r_d2.quat_y;
            r_p3[4]  <= r_tw * r_d2.quat_y;
            r_p3[5]  <= r_tx * r_d2.quat_z;
            r_p3[6]  <= r_ty * r_d2.quat_w;
            r_p3[7]  <= r_tz * r_d2.quat_x;
            r_p3[8]  <= r_tw * r_d2.quat_z;
            r_p3[9]  <= r_tx * r_d2.quat_y;
            r_p3[10] <= r_ty * r_d2.quat_x;
            r_p3[11] <= r_tz * r_d2.quat_w;
            r_n3     <= r_n2;

            r_rx <= -QRV_RW'(r_p3[0]) + QRV_RW'(r_p3[1]) - QRV_RW'(r_p3[2])
                  +  QRV_RW'(r_p3[3]);
            r_ry <= -QRV_RW'(r_p3[4]) + QRV_RW'(r_p3[5]) + QRV_RW'(r_p3[6])
                  -  QRV_RW'(r_p3[7]);
            r_rz <= -QRV_RW'(r_p3[8]) - QRV_RW'(r_p3[9]) + QRV_RW'(r_p3[10])
                  +  QRV_RW'(r_p3[11]);
            r_n4 <= r_n3;
            r_z4 <= (r_n3 == '0);
        end
    end

    assign o_rx   = r_rx;
    assign o_ry   = r_ry;
    assign o_rz   = r_rz;
    assign o_norm = r_n4;
    assign o_zero = r_z4;

endmodule

/* sv/qrv_div.sv */
// Pipelined restoring divider: rounded r/|q|^2 saturated to 16 bits.
// One quotient bit per stage. Depends on qrv_pkg.
module qrv_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qrv_pkg::QRV_RW-1:0]  i_num,
    input  logic        [qrv_pkg::QRV_NW-1:0]  i_den,
    output logic signed [qrv_pkg::QRV_DW-1:0]  o_res,
    output logic                               o_sat
);
    import qrv_pkg::*;

    logic [QRV_RW-1:0]    r_rem [0:QRV_QBITS];
    logic [QRV_NW-1:0]    r_den [0:QRV_QBITS];
    logic [QRV_QBITS-1:0] r_q   [0:QRV_QBITS];
    logic                 r_neg [0:QRV_QBITS];
    logic                 r_ovf [0:QRV_QBITS];

    logic [QRV_RW-1:0] abs_num;
    logic [QRV_RW-1:0] mag;

    // Adding half the divisor before truncating rounds ties away from zero.
    assign abs_num = i_num[QRV_RW-1] ? QRV_RW'(-i_num) : QRV_RW'(i_num);
    assign mag     = abs_num + QRV_RW'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= mag;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[QRV_RW-1];
            r_ovf[0] <= QRV_NW'(mag >> QRV_QBITS) >= i_den;
        end
    end

    for (genvar k = 0; k < QRV_QBITS; k++) begin : g_row
        logic [QRV_RW-1:0] sub_d;
        logic              take;

        assign sub_d = QRV_RW'(r_den[k]) << (QRV_QBITS - 1 - k);
        assign take  = (r_rem[k] >= sub_d);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? r_rem[k] - sub_d : r_rem[k];
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][QRV_QBITS-2:0], take};
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        o_sat = 1'b0;
        o_res = QRV_DW'(r_q[QRV_QBITS]);
        if (r_neg[QRV_QBITS]) begin
            if (r_ovf[QRV_QBITS] || (r_q[QRV_QBITS] > QRV_QBITS'(32768))) begin
                o_sat = 1'b1;
                o_res = 16'sh8000;
            end else begin
                o_res = QRV_DW'(-r_q[QRV_QBITS]);
            end
        end else if (r_ovf[QRV_QBITS] || (r_q[QRV_QBITS] > QRV_QBITS'(32767))) begin
            o_sat = 1'b1;
            o_res = 16'sh7fff;
        end
    end

endmodule

/* sv/quaternion_rotate_vector.sv */
// Top level of the quaternion vector rotation block.
// Uses qrv_pkg, qrv_prod and qrv_div.

// Rotates a Q8.8 vector by a Q2.14 quaternion as q*(0,v)*conj(q)/|q|^2, so a
// non-unit quaternion still gives a pure rotation. A transaction can be
// accepted on every clock cycle while o_stall is low. The accepting edge
// loads the first of 23 registers: four stages of multiply and add, one
// set-up stage and seventeen one-bit stages of the three dividers, then the
// output register. Behind the output register sits a one-entry skid buffer.
// While the output is stalled, the pipeline keeps moving until a result
// reaches its end with nowhere to go. That result fills the skid buffer, and
// only then is the input stalled. A zero quaternion gives a zero vector with
// zero_norm set; clipped components set saturated.
module quaternion_rotate_vector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qrv_pkg::t_qrv_in   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output qrv_pkg::t_qrv_out  o_data
);
    import qrv_pkg::*;

    logic                     en;
    logic [QRV_LAT-1:0]       r_vld;
    logic [QRV_DIV_LAT-1:0]   r_zero;
    logic signed [QRV_RW-1:0] rx, ry, rz;
    logic [QRV_NW-1:0]        norm;
    logic                     zero4;
    logic signed [QRV_DW-1:0] dx, dy, dz;
    logic                     sx, sy, sz;
    t_qrv_out                 tail;
    logic                     r_out_valid, r_skid_valid;
    t_qrv_out                 r_out, r_skid;
    logic                     out_free;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    qrv_prod u_prod (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_data),
        .o_rx   (rx),
        .o_ry   (ry),
        .o_rz   (rz),
        .o_norm (norm),
        .o_zero (zero4)
    );

    qrv_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(rx), .i_den(norm),
                     .o_res(dx), .o_sat(sx));
    qrv_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(ry), .i_den(norm),
                     .o_res(dy), .o_sat(sy));
    qrv_div u_div_z (.i_clk(i_clk), .i_en(en), .i_num(rz), .i_den(norm),
                     .o_res(dz), .o_sat(sz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[QRV_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= {r_zero[QRV_DIV_LAT-2:0], zero4};
        end
    end

    // The dividers give garbage for a zero divisor, so that case is forced.
    always_comb begin
        if (r_zero[QRV_DIV_LAT-1]) begin
            tail = '{rot_x: '0, rot_y: '0, rot_z: '0, zero_norm: 1'b1, saturated: 1'b0};
        end else begin
            tail = '{rot_x: dx, rot_y: dy, rot_z: dz, zero_norm: 1'b0,
                     saturated: sx | sy | sz};
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= r_vld[QRV_LAT-1];
                end
            end else if (en && r_vld[QRV_LAT-1]) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : tail;
        end else if (en && r_vld[QRV_LAT-1]) begin
            r_skid <= tail;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_zero_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_norm |->
            o_data.rot_x == 0 && o_data.rot_y == 0 && o_data.rot_z == 0 &&
            !o_data.saturated)
        else $error("zero-norm result is not zero");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.saturated |->
            o_data.rot_x == 16'sh7fff || o_data.rot_x == 16'sh8000 ||
            o_data.rot_y == 16'sh7fff || o_data.rot_y == 16'sh8000 ||
            o_data.rot_z == 16'sh7fff || o_data.rot_z == 16'sh8000)
        else $error("saturated flag without a clipped component");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> !r_skid_valid)
        else $error("skid entry not drained after the output moved");
`endif

endmodule

/* verif/quaternion_rotate_vector_checker.sv */
// Checker for the quaternion vector rotation block: predicts each rotation
// from the accepted input transactions and compares the results in order.
// Depends on qrv_pkg.
module quaternion_rotate_vector_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  qrv_pkg::t_qrv_in  i_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  qrv_pkg::t_qrv_out i_out_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_zero_seen,
    output int                o_sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import qrv_pkg::*;

    t_qrv_out rotations_due[$];

    // Rounded num/den with ties away from zero, clipped to 16 bits.
    function automatic logic [15:0] scale_clip(input longint num, input longint den,
                                               inout logic clipped);
        longint mag;
        longint qm;
        mag = (num < 0) ? -num : num;
        qm = (mag + den / 2) / den;
        if (num < 0) begin
            if (qm > 32768) begin
                clipped = 1'b1;
                qm = 32768;
            end
            return 16'(-qm);
        end
        if (qm > 32767) begin
            clipped = 1'b1;
            qm = 32767;
        end
        return 16'(qm);
    endfunction

    function automatic t_qrv_out rotate(input t_qrv_in d);
        longint qw, qx, qy, qz, vx, vy, vz, nrm;
        longint tw, tx, ty, tz, rx, ry, rz;
        logic clipped;
        t_qrv_out r;
        qw = d.quat_w; qx = d.quat_x; qy = d.quat_y; qz = d.quat_z;
        vx = d.vec_x; vy = d.vec_y; vz = d.vec_z;
        r = '0;
        clipped = 1'b0;
        nrm = qw * qw + qx * qx + qy * qy + qz * qz;
        if (nrm == 0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        tw = -qx * vx - qy * vy - qz * vz;
        tx = qw * vx + qy * vz - qz * vy;
        ty = qw * vy - qx * vz + qz * vx;
        tz = qw * vz + qx * vy - qy * vx;
        rx = -tw * qx + tx * qw - ty * qz + tz * qy;
        ry = -tw * qy + tx * qz + ty * qw - tz * qx;
        rz = -tw * qz - tx * qy + ty * qx + tz * qw;
        r.rot_x = scale_clip(rx, nrm, clipped);
        r.rot_y = scale_clip(ry, nrm, clipped);
        r.rot_z = scale_clip(rz, nrm, clipped);
        r.saturated = clipped;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    assign o_pending = rotations_due.size();

    initial begin
        o_errors = 0;
        o_results = 0;
        o_zero_seen = 0;
        o_sat_seen = 0;
    end

    always @(posedge i_clk) begin
        t_qrv_out want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) rotations_due.push_back(rotate(i_data));
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (rotations_due.size() == 0) begin
                    report("unexpected transaction", 0, 0);
                end else begin
                    want = rotations_due.pop_front();
                    if (i_out_data.rot_x !== want.rot_x)
                        report("rot_x", i_out_data.rot_x, want.rot_x);
                    if (i_out_data.rot_y !== want.rot_y)
                        report("rot_y", i_out_data.rot_y, want.rot_y);
                    if (i_out_data.rot_z !== want.rot_z)
                        report("rot_z", i_out_data.rot_z, want.rot_z);
                    if (i_out_data.zero_norm !== want.zero_norm)
                        report("zero_norm", i_out_data.zero_norm, want.zero_norm);
                    if (i_out_data.saturated !== want.saturated)
                        report("saturated", i_out_data.saturated, want.saturated);
                    if (want.zero_norm) o_zero_seen++;
                    if (want.saturated) o_sat_seen++;
                end
            end
        end
    end
endmodule

/* verif/quaternion_rotate_vector_tb.sv */
// Testbench top for the quaternion vector rotation block: drives directed and
// random transactions with bursty input and stalling output.
// Depends on qrv_pkg, quaternion_rotate_vector and its checker.
module quaternion_rotate_vector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qrv_pkg::*;

    localparam int N_RANDOM = 1530;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_qrv_in  in_data;
    logic     out_valid;
    logic     out_stall;
    t_qrv_out out_data;
    int       errors, pending, results, zero_seen, sat_seen;
    bit       hold_off;
    t_qrv_in  directed_items[$];

    quaternion_rotate_vector i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_data(in_data), .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    quaternion_rotate_vector_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_zero_seen(zero_seen), .o_sat_seen(sat_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 16)) - 8);
            4: return 16'h4000;
            5: return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_qrv_in random_item();
        t_qrv_in d;
        d.quat_w = pick_component();
        d.quat_x = pick_component();
        d.quat_y = pick_component();
        d.quat_z = pick_component();
        d.vec_x = pick_component();
        d.vec_y = pick_component();
        d.vec_z = pick_component();
        // Sometimes use a zero or near-zero quaternion.
        if ($urandom_range(0, 19) == 0) {d.quat_w, d.quat_x, d.quat_y, d.quat_z} = '0;
        if ($urandom_range(0, 19) == 0) begin
            {d.quat_x, d.quat_y, d.quat_z} = '0;
            d.quat_w = 16'($urandom_range(1, 3));
        end
        return d;
    endfunction

    // Offers one transaction and holds it until the block takes it.
    task automatic send(input t_qrv_in d);
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Receiver: random stall pattern, quiet stretches, and one long hold-off.
    initial begin
        int mode;
        out_stall = 1'b0;
        mode = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) out_stall <= 1'b1;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        int hold_cycles;
        hold_off = 1'b0;
        wait (results > 300);
        hold_off = 1'b1;
        for (hold_cycles = 0; hold_cycles < 120; hold_cycles++) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        t_qrv_in d;
        int burst;
        int gap;
        int settle;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, zero quaternion, extremes, non-unit and rotations.
        directed_items.push_back('{16'h4000, 0, 0, 0, 16'h0100, 16'h0200, 16'hfd00});
        directed_items.push_back('{0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h1234});
        directed_items.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                   16'h7fff, 16'h7fff, 16'h7fff});
        directed_items.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                   16'h8000, 16'h8000, 16'h8000});
        directed_items.push_back('{16'h2d41, 0, 0, 16'h2d41, 16'h7fff, 16'h7fff, 0});
        directed_items.push_back('{16'h2000, 16'h2000, 16'h2000, 16'h2000,
                                   16'h7000, 16'h7000, 16'h7000});
        directed_items.push_back('{16'h0001, 0, 0, 0, 16'h8000, 16'h7fff, 16'h0001});
        directed_items.push_back('{0, 16'h4000, 0, 0, 16'h0100, 16'h0100, 16'h0100});
        directed_items.push_back('{0, 0, 16'h8000, 0, 16'hffff, 16'h0001, 16'h8000});
        directed_items.push_back('{0, 0, 0, 16'h7fff, 16'h5555, 16'haaaa, 16'h0000});
        directed_items.push_back('{16'h0001, 16'h0001, 0, 0, 16'h0001, 16'h0001, 16'h0001});
        directed_items.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                   16'h7fff, 16'h8000, 16'h7fff});
        foreach (directed_items[k]) send(directed_items[k]);

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                d = random_item();
                send(d);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        settle = 0;
        while (pending > 0 && settle < 100000) begin
            @(posedge clk);
            settle++;
        end
        repeat (QRV_LAT + 10) @(posedge clk);

        $display("Run covered %0d rotations, %0d with a zero quaternion, %0d saturated.",
                 results, zero_seen, sat_seen);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
